### src/alr_pkg.sv
package alr_pkg;

    localparam int SPAN     = 64;
    localparam int COORD_W  = $clog2(SPAN);
    localparam int FRAC_W   = 16;
    localparam int CH_W     = 8;
    localparam int YPOS_W   = COORD_W + FRAC_W;
    localparam int CNT_W    = COORD_W + 1;
    localparam int RGB_W    = 16;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // line kinds
    localparam logic KIND_PLAIN = 1'b0;   // axis-aligned or exact diagonal
    localparam logic KIND_WU    = 1'b1;   // general antialiased line

    // per-step coordinate motion for plain lines
    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_INC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;

    typedef struct packed {
        logic               kind;
        logic               steep;
        logic               neg;      // minor axis runs downward
        logic [COORD_W-1:0] a0;       // plain: start col; wu: major start
        logic [COORD_W-1:0] b0;       // plain: start row; wu: minor start
        logic [COORD_W-1:0] a1;
        logic [COORD_W-1:0] b1;
        logic [1:0]         cmode;
        logic [1:0]         rmode;
        logic [CNT_W-1:0]   count;    // results of this line
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
        logic [RGB_W-1:0]   color;
    } t_line_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### src/antialiased_line_rasterizer.sv
// Antialiased line rasterizer (Wu stepping, 16 fraction bits). One input
// transaction is a line: two endpoints on a 64x64 panel and an RGB565 color.
// The block returns the line as a series of output transactions, each with
// up to two pixels; last_step marks the final one. A front stage classifies
// the line (axis-aligned, exact diagonal or general) and hands a descriptor
// to a two-entry queue, so a new line is taken while the previous one is
// still being drawn. The back end draws one line at a time: a general line
// first runs a bit-serial divider that forms the gradient, then, while the
// output is not stalled, emits one transaction per cycle along the major axis
// (the endpoint pair first, then every inner column split between row y and
// row y+1). Axis-aligned lines and exact diagonals need no division and emit
// one full-color pixel per cycle when not stalled; a single point yields no
// transaction. Output stall holds the result register and pauses the stepper
// only; the divider keeps running.
module antialiased_line_rasterizer
    import alr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_start_x,
    input  logic [5:0]  i_start_y,
    input  logic [5:0]  i_end_x,
    input  logic [5:0]  i_end_y,
    input  logic [15:0] i_line_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_first_col,
    output logic [5:0]  o_first_row,
    output logic [7:0]  o_first_red,
    output logic [7:0]  o_first_green,
    output logic [7:0]  o_first_blue,
    output logic [6:0]  o_second_col,
    output logic [6:0]  o_second_row,
    output logic [7:0]  o_second_red,
    output logic [7:0]  o_second_green,
    output logic [7:0]  o_second_blue,
    output logic        o_second_valid,
    output logic        o_last_step
);

    t_line_desc front_desc;
    t_line_desc q_desc;
    t_q_stat    q_stat;
    logic       q_push;
    logic       q_pop;

    // classify and register the request
    alr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_desc       (front_desc)
    );

    // decouples classification from drawing
    alr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_desc  (q_desc),
        .o_stat  (q_stat)
    );

    // gradient divider, stepper and output register
    alr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc         (q_desc),
        .i_q_stat       (q_stat),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_first_col    (o_first_col),
        .o_first_row    (o_first_row),
        .o_first_red    (o_first_red),
        .o_first_green  (o_first_green),
        .o_first_blue   (o_first_blue),
        .o_second_col   (o_second_col),
        .o_second_row   (o_second_row),
        .o_second_red   (o_second_red),
        .o_second_green (o_second_green),
        .o_second_blue  (o_second_blue),
        .o_second_valid (o_second_valid),
        .o_last_step    (o_last_step)
    );

`ifndef SYNTH
    // queue occupancy is never contradictory
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // front only pushes into a queue with room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // an unused neighbor pixel is all zero
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_second_valid) |-> (o_second_col == 7'd0 && o_second_row == 7'd0
            && o_second_red == 8'd0 && o_second_green == 8'd0 && o_second_blue == 8'd0))
        else $error("unused neighbor pixel not cleared");

    // neighbor pixel stays at most one past the panel edge
    a_second_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_second_valid) |-> (o_second_col <= 7'd64 && o_second_row <= 7'd64))
        else $error("neighbor pixel out of span");
`endif

endmodule

### src/alr_front.sv
module alr_front
    import alr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [5:0]         i_start_x,
    input  logic [5:0]         i_start_y,
    input  logic [5:0]         i_end_x,
    input  logic [5:0]         i_end_y,
    input  logic [15:0]        i_line_color,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_line_desc         o_desc
);

    logic               r_vld;
    t_line_desc         r_desc;
    t_line_desc         n_desc;
    logic               accept;
    logic               nonempty;
    logic [COORD_W-1:0] dx, dy;
    logic               xneg, yneg, steep;
    logic [COORD_W-1:0] pa0, pb0, pa1, pb1;

    assign o_stall = r_vld && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_q_stat.full;
    assign o_desc  = r_desc;

    always_comb begin
        xneg     = i_end_x < i_start_x;
        yneg     = i_end_y < i_start_y;
        dx       = xneg ? i_start_x - i_end_x : i_end_x - i_start_x;
        dy       = yneg ? i_start_y - i_end_y : i_end_y - i_start_y;
        nonempty = (dx != '0) || (dy != '0);
        steep    = dy > dx;
        pa0      = steep ? i_start_y : i_start_x;
        pb0      = steep ? i_start_x : i_start_y;
        pa1      = steep ? i_end_y : i_end_x;
        pb1      = steep ? i_end_x : i_end_y;

        n_desc       = '0;
        n_desc.color = i_line_color;
        if (dx == '0) begin
            n_desc.kind  = KIND_PLAIN;
            n_desc.a0    = i_start_x;
            n_desc.b0    = yneg ? i_end_y : i_start_y;
            n_desc.cmode = MODE_HOLD;
            n_desc.rmode = MODE_INC;
            n_desc.count = {1'b0, dy};
        end else if (dy == '0) begin
            n_desc.kind  = KIND_PLAIN;
            n_desc.a0    = xneg ? i_end_x : i_start_x;
            n_desc.b0    = i_start_y;
            n_desc.cmode = MODE_INC;
            n_desc.rmode = MODE_HOLD;
            n_desc.count = {1'b0, dx};
        end else if (dx == dy) begin
            n_desc.kind  = KIND_PLAIN;
            n_desc.a0    = i_start_x;
            n_desc.b0    = i_start_y;
            n_desc.cmode = xneg ? MODE_DEC : MODE_INC;
            n_desc.rmode = yneg ? MODE_DEC : MODE_INC;
            n_desc.count = {1'b0, dx} + CNT_W'(1);
        end else begin
            n_desc.kind  = KIND_WU;
            n_desc.steep = steep;
            // walk the major axis upward
            if (pa0 > pa1) begin
                n_desc.a0 = pa1;
                n_desc.b0 = pb1;
                n_desc.a1 = pa0;
                n_desc.b1 = pb0;
            end else begin
                n_desc.a0 = pa0;
                n_desc.b0 = pb0;
                n_desc.a1 = pa1;
                n_desc.b1 = pb1;
            end
            n_desc.neg   = n_desc.b1 < n_desc.b0;
            n_desc.dmaj  = steep ? dy : dx;
            n_desc.dmin  = steep ? dx : dy;
            n_desc.count = {1'b0, n_desc.dmaj};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= nonempty;      // a single point yields nothing
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

### src/alr_queue.sv
module alr_queue
    import alr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_line_desc i_desc,
    input  logic       i_pop,
    output t_line_desc o_desc,
    output t_q_stat    o_stat
);

    t_line_desc          r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;

    assign o_stat.full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_desc       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

### src/alr_back.sv
module alr_back
    import alr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_line_desc  i_desc,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_first_col,
    output logic [5:0]  o_first_row,
    output logic [7:0]  o_first_red,
    output logic [7:0]  o_first_green,
    output logic [7:0]  o_first_blue,
    output logic [6:0]  o_second_col,
    output logic [6:0]  o_second_row,
    output logic [7:0]  o_second_red,
    output logic [7:0]  o_second_green,
    output logic [7:0]  o_second_blue,
    output logic        o_second_valid,
    output logic        o_last_step
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]               r_state;
    logic                     r_kind, r_steep, r_neg, r_first;
    logic [COORD_W-1:0]       r_a, r_b, r_a1, r_b1, r_dmaj, r_rem;
    logic [1:0]               r_cmode, r_rmode;
    logic [CNT_W-1:0]         r_cnt;
    logic [FRAC_W-1:0]        r_quo;
    logic [$clog2(FRAC_W)-1:0] r_bit;
    logic [YPOS_W-1:0]        r_ypos;
    logic [RGB_W-1:0]         r_color;

    logic                     r_o_valid;
    logic [5:0]               r_o_first_col, r_o_first_row;
    logic [7:0]               r_o_first_red, r_o_first_green, r_o_first_blue;
    logic [6:0]               r_o_second_col, r_o_second_row;
    logic [7:0]               r_o_second_red, r_o_second_green, r_o_second_blue;
    logic                     r_o_second_valid, r_o_last_step;

    logic                     out_free, emit, div_ge, last;
    logic [COORD_W:0]         div_t;
    logic [YPOS_W-1:0]        grad, q_ext;
    logic [CH_W-1:0]          cr, cg, cb, frac, sr, sg, sb;
    logic [2*CH_W-1:0]        pr, pg, pb;
    logic [COORD_W-1:0]       row;
    logic [COORD_W:0]         row_nb;

    assign out_free = !r_o_valid || !i_stall;
    assign emit     = (r_state == S_RUN) && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign last     = r_cnt == CNT_W'(1);

    // one restoring-division step per cycle
    assign div_t  = {r_rem, 1'b0};
    assign div_ge = div_t >= {1'b0, r_dmaj};

    assign q_ext = {{COORD_W{1'b0}}, r_quo};
    assign grad  = r_neg ? (~q_ext + YPOS_W'(1)) : q_ext;

    // RGB565 to 888 by zero fill
    assign cr = {r_color[15:11], 3'b000};
    assign cg = {r_color[10:5], 2'b00};
    assign cb = {r_color[4:0], 3'b000};

    assign frac   = r_ypos[FRAC_W-1 -: CH_W];
    assign pr     = cr * frac;
    assign pg     = cg * frac;
    assign pb     = cb * frac;
    assign sr     = pr[2*CH_W-1 -: CH_W];
    assign sg     = pg[2*CH_W-1 -: CH_W];
    assign sb     = pb[2*CH_W-1 -: CH_W];
    assign row    = r_ypos[YPOS_W-1 -: COORD_W];
    assign row_nb = {1'b0, row} + (COORD_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= (i_desc.kind == KIND_WU) ? S_DIV : S_RUN;
                    end
                end
                S_DIV: begin
                    if (r_bit == ($clog2(FRAC_W))'(FRAC_W-1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (emit && last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_desc.kind;
            r_steep <= i_desc.steep;
            r_neg   <= i_desc.neg;
            r_a     <= i_desc.a0;
            r_b     <= i_desc.b0;
            r_a1    <= i_desc.a1;
            r_b1    <= i_desc.b1;
            r_cmode <= i_desc.cmode;
            r_rmode <= i_desc.rmode;
            r_cnt   <= i_desc.count;
            r_dmaj  <= i_desc.dmaj;
            r_rem   <= i_desc.dmin;
            r_color <= i_desc.color;
            r_bit   <= '0;
            r_first <= 1'b1;
        end
        if (r_state == S_DIV) begin
            r_rem <= div_ge ? COORD_W'(div_t - {1'b0, r_dmaj}) : div_t[COORD_W-1:0];
            r_quo <= {r_quo[FRAC_W-2:0], div_ge};
            r_bit <= r_bit + 1'b1;
        end
        if (emit) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_kind == KIND_WU) begin
                r_first <= 1'b0;
                r_a     <= r_a + 1'b1;
                if (r_first) begin
                    r_ypos <= {r_b, {FRAC_W{1'b0}}} + grad;
                end else begin
                    r_ypos <= r_ypos + grad;
                end
            end else begin
                case (r_cmode)
                    MODE_INC: r_a <= r_a + 1'b1;
                    MODE_DEC: r_a <= r_a - 1'b1;
                    default:  r_a <= r_a;
                endcase
                case (r_rmode)
                    MODE_INC: r_b <= r_b + 1'b1;
                    MODE_DEC: r_b <= r_b - 1'b1;
                    default:  r_b <= r_b;
                endcase
            end

            r_o_last_step <= last;
            if (r_kind == KIND_PLAIN) begin
                r_o_first_col    <= r_a;
                r_o_first_row    <= r_b;
                r_o_first_red    <= cr;
                r_o_first_green  <= cg;
                r_o_first_blue   <= cb;
                r_o_second_valid <= 1'b0;
                r_o_second_col   <= '0;
                r_o_second_row   <= '0;
                r_o_second_red   <= '0;
                r_o_second_green <= '0;
                r_o_second_blue  <= '0;
            end else if (r_first) begin
                // both endpoints, full color
                r_o_first_col    <= r_steep ? r_b : r_a;
                r_o_first_row    <= r_steep ? r_a : r_b;
                r_o_first_red    <= cr;
                r_o_first_green  <= cg;
                r_o_first_blue   <= cb;
                r_o_second_valid <= 1'b1;
                r_o_second_col   <= {1'b0, r_steep ? r_b1 : r_a1};
                r_o_second_row   <= {1'b0, r_steep ? r_a1 : r_b1};
                r_o_second_red   <= cr;
                r_o_second_green <= cg;
                r_o_second_blue  <= cb;
            end else begin
                r_o_first_col    <= r_steep ? row : r_a;
                r_o_first_row    <= r_steep ? r_a : row;
                r_o_first_red    <= cr - sr;
                r_o_first_green  <= cg - sg;
                r_o_first_blue   <= cb - sb;
                r_o_second_valid <= 1'b1;
                r_o_second_col   <= r_steep ? row_nb : {1'b0, r_a};
                r_o_second_row   <= r_steep ? {1'b0, r_a} : row_nb;
                r_o_second_red   <= sr;
                r_o_second_green <= sg;
                r_o_second_blue  <= sb;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_first_col    = r_o_first_col;
    assign o_first_row    = r_o_first_row;
    assign o_first_red    = r_o_first_red;
    assign o_first_green  = r_o_first_green;
    assign o_first_blue   = r_o_first_blue;
    assign o_second_col   = r_o_second_col;
    assign o_second_row   = r_o_second_row;
    assign o_second_red   = r_o_second_red;
    assign o_second_green = r_o_second_green;
    assign o_second_blue  = r_o_second_blue;
    assign o_second_valid = r_o_second_valid;
    assign o_last_step    = r_o_last_step;

endmodule
